>>> rtl/skrt_pkg.sv
package skrt_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int DATA_W = 264;

  localparam logic [2:0] CMD_INSERT   = 3'd0;
  localparam logic [2:0] CMD_UPDATE   = 3'd1;
  localparam logic [2:0] CMD_DELETE   = 3'd2;
  localparam logic [2:0] CMD_READ_FWD = 3'd3;
  localparam logic [2:0] CMD_READ_REV = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_RANK      = 3'd4;

  typedef struct packed {
    logic [63:0] salary_bits;
    logic [31:0] name_high;
    logic [63:0] name_mid;
    logic [63:0] name_low;
    logic [31:0] key;
  } rec_t;

  typedef struct packed {
    logic [3:0] rank;
    rec_t       rec;
    logic [2:0] command;
  } req_t;

  typedef struct packed {
    logic ins;
    logic upd;
    logic del;
  } cell_ctrl_t;

  function automatic logic key_lt(logic [31:0] a, logic [31:0] b);
    key_lt = $signed(a) < $signed(b);
  endfunction

endpackage

>>> rtl/skrt_cell.sv
module skrt_cell import skrt_pkg::*; (
  input  logic        clk,
  input  cell_ctrl_t  ctrl,
  input  rec_t        new_rec,
  input  rec_t        left_rec,
  input  rec_t        right_rec,
  input  logic        occ,
  input  logic        left_lt,
  input  logic        left_ge,
  output logic        lt,
  output logic        ge,
  output logic        eq,
  output rec_t        rec
);

  rec_t rec_r;
  rec_t rec_nxt;
  logic below;

  assign below = key_lt(rec_r.key, new_rec.key);
  assign lt    = occ & below;
  assign ge    = occ & ~below;
  assign eq    = occ & (rec_r.key == new_rec.key);
  assign rec   = rec_r;

  always_comb begin
    rec_nxt = rec_r;
    if (ctrl.ins) begin
      if (left_ge) begin
        rec_nxt = left_rec;
      end else if (!lt) begin
        rec_nxt = new_rec;
      end
    end else if (ctrl.upd && eq && left_lt) begin
      rec_nxt.name_low    = new_rec.name_low;
      rec_nxt.name_mid    = new_rec.name_mid;
      rec_nxt.name_high   = new_rec.name_high;
      rec_nxt.salary_bits = new_rec.salary_bits;
    end else if (ctrl.del && !lt) begin
      rec_nxt = right_rec;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule

>>> rtl/sorted_keyed_record_table.sv
// Each request is captured into a request register, then applied to the cells as its result is registered.
// One request is held from capture until its result is registered, so a new
// request is not taken before the last one is through; a result stalled at
// the output holds the next request back.
// Reset: synchronous, active low; clears the record count and the handshake
// state. Record storage is not cleared.
module sorted_keyed_record_table import skrt_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // command, key, name_low, name_mid, name_high, salary_bits, rank, pad
  input  logic [DATA_W-1:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // status, out_key, out_name_low, out_name_mid, out_name_high,
  // out_salary_bits, entry_count
  output logic [DATA_W-1:0] m_axis_tdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = CW + 4;

  logic           busy_r, busy_nxt;
  logic           ovalid_r, ovalid_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  req_t           req_r;
  logic [DATA_W-1:0] odata_r, odata_nxt;

  logic           accept, fire;
  logic           empty, full, found, rank_bad, read_cmd;
  logic [2:0]     status;
  cell_ctrl_t     ctrl;
  logic [XW-1:0]  rank_x, cnt_x, pos_x;
  logic [CW+4:0]  cnt_wide;
  rec_t           rd_rec, out_rec;

  logic [DEPTH-1:0] lt_v, ge_v, eq_v, sel_v;
  rec_t             rec_v [DEPTH];
  logic             read_ok;

  assign s_axis_tready = ~busy_r;
  assign accept        = s_axis_tvalid & ~busy_r;
  assign fire          = busy_r & (~ovalid_r | m_axis_tready);
  assign m_axis_tvalid = ovalid_r;
  assign m_axis_tdata  = odata_r;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CW'(DEPTH));
  assign found    = |eq_v;
  assign rank_x   = XW'(req_r.rank);
  assign cnt_x    = XW'(count_r);
  assign rank_bad = (rank_x >= cnt_x);
  assign read_cmd = req_r.command inside {CMD_READ_FWD, CMD_READ_REV};
  assign pos_x    = (req_r.command == CMD_READ_FWD) ? rank_x : (cnt_x - XW'(1) - rank_x);

  always_comb begin
    ctrl     = '0;
    status   = ST_OK;
    read_ok  = 1'b0;
    count_nxt = count_r;
    case (req_r.command)
      CMD_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.ins  = fire;
          count_nxt = count_r + CW'(1);
        end
      end
      CMD_UPDATE, CMD_DELETE: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (!found) begin
          status = ST_NOT_FOUND;
        end else if (req_r.command == CMD_UPDATE) begin
          ctrl.upd = fire;
        end else begin
          ctrl.del  = fire;
          count_nxt = count_r - CW'(1);
        end
      end
      CMD_READ_FWD, CMD_READ_REV: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (rank_bad) begin
          status = ST_RANK;
        end else begin
          read_ok = 1'b1;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic occ;
    assign occ      = (CW'(i) < count_r);
    assign sel_v[i] = (pos_x == XW'(i));
    if (i == 0) begin : g_first
      skrt_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .new_rec   (req_r.rec),
        .left_rec  (req_r.rec),
        .right_rec (rec_v[(DEPTH > 1) ? 1 : 0]),
        .occ       (occ),
        .left_lt   (1'b1),
        .left_ge   (1'b0),
        .lt        (lt_v[i]),
        .ge        (ge_v[i]),
        .eq        (eq_v[i]),
        .rec       (rec_v[i])
      );
    end else if (i == DEPTH - 1) begin : g_last
      skrt_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .new_rec   (req_r.rec),
        .left_rec  (rec_v[i-1]),
        .right_rec (req_r.rec),
        .occ       (occ),
        .left_lt   (lt_v[i-1]),
        .left_ge   (ge_v[i-1]),
        .lt        (lt_v[i]),
        .ge        (ge_v[i]),
        .eq        (eq_v[i]),
        .rec       (rec_v[i])
      );
    end else begin : g_mid
      skrt_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .new_rec   (req_r.rec),
        .left_rec  (rec_v[i-1]),
        .right_rec (rec_v[i+1]),
        .occ       (occ),
        .left_lt   (lt_v[i-1]),
        .left_ge   (ge_v[i-1]),
        .lt        (lt_v[i]),
        .ge        (ge_v[i]),
        .eq        (eq_v[i]),
        .rec       (rec_v[i])
      );
    end
  end

  always_comb begin
    rd_rec = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (sel_v[i]) begin
        rd_rec = rd_rec | rec_v[i];
      end
    end
  end

  assign out_rec  = (read_cmd && read_ok) ? rd_rec : '0;
  assign cnt_wide = (CW + 5)'(count_nxt);

  always_comb begin
    busy_nxt   = busy_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    if (ovalid_r && m_axis_tready) begin
      ovalid_nxt = 1'b0;
    end
    if (fire) begin
      busy_nxt   = 1'b0;
      ovalid_nxt = 1'b1;
      odata_nxt  = {cnt_wide[4:0], out_rec, status};
    end else if (accept) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
      count_r  <= '0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
      if (fire) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
    if (accept) begin
      req_r <= s_axis_tdata[$bits(req_t)-1:0];
    end
  end

endmodule

>>> rtl/skrt_checker.sv
module skrt_checker import skrt_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input logic              clk,
  input logic              rst_n,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic [DATA_W-1:0] s_axis_tdata,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [DATA_W-1:0] m_axis_tdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW+4:0] DEPTH_X = (CW + 5)'(DEPTH);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while one is in progress");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid && m_axis_tdata[2:0] == ST_FULL |-> m_axis_tdata[263:259] == DEPTH_X[4:0])
    else $error("full status with a short table");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid && m_axis_tdata[2:0] == ST_EMPTY |-> m_axis_tdata[263:259] == 5'd0)
    else $error("empty status with records held");

  a_zero_record: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid && m_axis_tdata[2:0] != ST_OK |-> m_axis_tdata[258:3] == '0)
    else $error("record fields set on a failed request");

endmodule

bind sorted_keyed_record_table skrt_checker #(.DEPTH(DEPTH)) u_skrt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> test/tb_sorted_keyed_record_table.sv
module tb_sorted_keyed_record_table;
  import skrt_pkg::*;

  localparam int TABLE_DEPTH = DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;

  // status lowest, entry_count highest
  typedef struct packed {
    logic [4:0]  entry_count;
    logic [63:0] salary_bits;
    logic [31:0] name_high;
    logic [63:0] name_mid;
    logic [63:0] name_low;
    logic [31:0] key;
    logic [2:0]  status;
  } table_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // command, key, name_low, name_mid, name_high, salary_bits, rank, pad
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // status, out_key, out_name_low, out_name_mid, out_name_high,
  // out_salary_bits, entry_count
  logic [DATA_W-1:0] m_axis_tdata;

  rec_t          table_recs [TABLE_DEPTH];
  int unsigned   table_count = 0;
  table_result_t expected_results [$];
  int            fail_count = 0;
  int            cycle_count = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            recv_hold_len = 0;

  sorted_keyed_record_table #(.DEPTH(TABLE_DEPTH)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic table_result_t apply_request(req_t r);
    table_result_t res;
    int unsigned   pos;
    int unsigned   i;
    res = '0;
    res.status = ST_OK;
    case (r.command)
      CMD_INSERT: begin
        if (table_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < table_count && $signed(table_recs[pos].key) < $signed(r.rec.key))
            pos++;
          for (i = table_count; i > pos; i--)
            table_recs[i] = table_recs[i-1];
          table_recs[pos] = r.rec;
          table_count++;
        end
      end
      CMD_UPDATE, CMD_DELETE: begin
        if (table_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          pos = 0;
          while (pos < table_count && table_recs[pos].key != r.rec.key)
            pos++;
          if (pos >= table_count) begin
            res.status = ST_NOT_FOUND;
          end else if (r.command == CMD_UPDATE) begin
            table_recs[pos].name_low    = r.rec.name_low;
            table_recs[pos].name_mid    = r.rec.name_mid;
            table_recs[pos].name_high   = r.rec.name_high;
            table_recs[pos].salary_bits = r.rec.salary_bits;
          end else begin
            for (i = pos; i + 1 < table_count; i++)
              table_recs[i] = table_recs[i+1];
            table_count--;
          end
        end
      end
      CMD_READ_FWD, CMD_READ_REV: begin
        if (table_count == 0) begin
          res.status = ST_EMPTY;
        end else if (r.rank >= table_count) begin
          res.status = ST_RANK;
        end else begin
          pos = (r.command == CMD_READ_FWD) ? r.rank : table_count - 1 - r.rank;
          res.key         = table_recs[pos].key;
          res.name_low    = table_recs[pos].name_low;
          res.name_mid    = table_recs[pos].name_mid;
          res.name_high   = table_recs[pos].name_high;
          res.salary_bits = table_recs[pos].salary_bits;
        end
      end
      default: ;
    endcase
    res.entry_count = table_count[4:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst_n && s_axis_tvalid && s_axis_tready)
      expected_results.push_back(apply_request(req_t'(s_axis_tdata[$bits(req_t)-1:0])));
  end

  function automatic void check_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", fname, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    table_result_t got;
    table_result_t exp_r;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_results.size() == 0) begin
        $error("result with no request pending: %h", m_axis_tdata);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("status", exp_r.status, got.status);
        check_field("out_key", exp_r.key, got.key);
        check_field("out_name_low", exp_r.name_low, got.name_low);
        check_field("out_name_mid", exp_r.name_mid, got.name_mid);
        check_field("out_name_high", exp_r.name_high, got.name_high);
        check_field("out_salary_bits", exp_r.salary_bits, got.salary_bits);
        check_field("entry_count", exp_r.entry_count, got.entry_count);
      end
    end
  end

  // result side; long hold-off counted here
  always @(posedge clk) begin
    if (recv_hold_len > 0) begin
      m_axis_tready <= 1'b0;
      recv_hold_len--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_request(input req_t r);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, r};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic req_t make_req(logic [2:0] cmd, logic [31:0] k, logic [63:0] p,
                                    logic [3:0] rnk);
    req_t r;
    r.command             = cmd;
    r.rec.key             = k;
    r.rec.name_low        = p;
    r.rec.name_mid        = ~p;
    r.rec.name_high       = p[63:32] ^ p[31:0];
    r.rec.salary_bits     = {p[31:0], p[63:32]};
    r.rank                = rnk;
    return r;
  endfunction

  function automatic logic [31:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel <= 4 && table_count > 0)
      return table_recs[$urandom_range(table_count - 1)].key;
    if (sel <= 7)
      return $urandom_range(15) - 8;
    if (sel == 8)
      return $urandom;
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic req_t make_random_req(int ins_pct);
    req_t        r;
    int unsigned c;
    r.rec.key         = pick_key();
    r.rec.name_low    = {$urandom, $urandom};
    r.rec.name_mid    = {$urandom, $urandom};
    r.rec.name_high   = $urandom;
    r.rec.salary_bits = {$urandom, $urandom};
    r.rank            = 4'($urandom_range(15));
    if ($urandom_range(99) < ins_pct) begin
      r.command = CMD_INSERT;
    end else begin
      c = $urandom_range(99);
      if (c < 22)      r.command = CMD_UPDATE;
      else if (c < 50) r.command = CMD_DELETE;
      else if (c < 72) r.command = CMD_READ_FWD;
      else if (c < 94) r.command = CMD_READ_REV;
      else             r.command = 3'($urandom_range(7, 5));
    end
    // small ranks are the ones that hit on a partly filled table
    if (r.command inside {CMD_READ_FWD, CMD_READ_REV} && table_count > 0 && $urandom_range(3) != 0)
      r.rank = 4'($urandom_range(table_count - 1));
    return r;
  endfunction

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_empty_table();
    send_request(make_req(CMD_READ_FWD, 32'h0, 64'h0, 4'd0));
    send_request(make_req(CMD_READ_REV, 32'h0, 64'h0, 4'd15));
    send_request(make_req(CMD_UPDATE, 32'h0, '1, 4'd0));
    send_request(make_req(CMD_DELETE, 32'h8000_0000, 64'h0, 4'd0));
    send_request(make_req(3'd5, 32'hffff_ffff, '1, 4'd15));
  endtask

  task automatic test_order_and_lookup();
    send_request(make_req(CMD_INSERT, 32'h7fff_ffff, '1, 4'd15));
    send_request(make_req(CMD_INSERT, 32'h8000_0000, 64'h0, 4'd0));
    // equal to head key: goes in front
    send_request(make_req(CMD_INSERT, 32'h8000_0000, 64'h0123_4567_89ab_cdef, 4'd0));
    send_request(make_req(CMD_INSERT, 32'hffff_ffff, 64'hdead_beef_5a5a_a5a5, 4'd0));
    send_request(make_req(CMD_READ_FWD, 32'h0, 64'h0, 4'd0));
    send_request(make_req(CMD_READ_FWD, 32'h0, 64'h0, 4'd1));
    send_request(make_req(CMD_READ_REV, 32'h0, 64'h0, 4'd0));
    send_request(make_req(CMD_READ_FWD, 32'h0, 64'h0, 4'd4));
    send_request(make_req(CMD_READ_REV, 32'h0, 64'h0, 4'd15));
    send_request(make_req(CMD_UPDATE, 32'h8000_0000, '1, 4'd0));
    send_request(make_req(CMD_READ_FWD, 32'h0, 64'h0, 4'd0));
    send_request(make_req(CMD_UPDATE, 32'h5, '1, 4'd0));
    send_request(make_req(CMD_DELETE, 32'h5, '1, 4'd0));
    send_request(make_req(CMD_DELETE, 32'h8000_0000, 64'h0, 4'd0));
    send_request(make_req(CMD_READ_FWD, 32'h0, 64'h0, 4'd0));
    send_request(make_req(3'd6, 32'h8000_0000, 64'h0, 4'd0));
    send_request(make_req(3'd7, 32'h7fff_ffff, '1, 4'd7));
    send_request(make_req(CMD_DELETE, 32'h7fff_ffff, 64'h0, 4'd0));
    send_request(make_req(CMD_DELETE, 32'h8000_0000, 64'h0, 4'd0));
    send_request(make_req(CMD_DELETE, 32'hffff_ffff, 64'h0, 4'd0));
    send_request(make_req(CMD_READ_REV, 32'h0, 64'h0, 4'd0));
  endtask

  task automatic test_full_table();
    int k;
    for (k = 0; k <= TABLE_DEPTH; k++)
      send_request(make_req(CMD_INSERT, 32'(TABLE_DEPTH / 2 - k), {2{32'(k)}}, 4'd0));
    send_request(make_req(CMD_READ_FWD, 32'h0, 64'h0, 4'd15));
    send_request(make_req(CMD_READ_REV, 32'h0, 64'h0, 4'd15));
    for (k = 0; k < TABLE_DEPTH; k++)
      send_request(make_req(CMD_DELETE, 32'(TABLE_DEPTH / 2 - k), 64'h0, 4'd0));
  endtask

  task automatic test_random(int n, int snd_idle, int rcv_idle);
    int k;
    int ins_pct;
    send_idle_pct = snd_idle;
    recv_idle_pct = rcv_idle;
    for (k = 0; k < n; k++) begin
      // swing fill level between empty and full
      ins_pct = ((k / 48) % 2 == 0) ? 60 : 15;
      send_request(make_random_req(ins_pct));
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    int k;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold_len = 300;
    for (k = 0; k < 60; k++)
      send_request(make_random_req(50));
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_order_and_lookup();
    test_full_table();
    wait_drained();
    test_random(430, 21, 64);
    test_random(430, 64, 21);
    test_random(430, 0, 0);
    test_backpressure();
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
